@@ sv/assert_macros.svh @@
// Assertion helpers; clock and reset are taken from the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ sv/crx_pkg.sv @@
`timescale 1ns / 1ps
package crx_pkg;

   localparam int WORD_COUNT    = 10;
   localparam int PAYLOAD_BYTES = 4 * WORD_COUNT;
   localparam int COUNT_W       = $clog2(PAYLOAD_BYTES + 1);
   localparam int WADDR_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

   localparam logic [7:0] START_BYTE = 8'h24;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_COLLECT = 2'd1,
      MODE_CHECK   = 2'd2,
      MODE_DONE    = 2'd3
   } rx_mode_type;

   typedef enum logic [1:0] {
      ST_BYTE,
      ST_READ,
      ST_LOAD
   } fsm_state_type;

   typedef struct packed {
      logic               wr_en;
      logic [WADDR_W-1:0] wr_addr;
      logic [1:0]         wr_lane;
      logic [7:0]         wr_data;
      logic               rd_en;
      logic [WADDR_W-1:0] rd_addr;
   } ram_cmd_type;

   typedef struct packed {
      logic        load;
      rx_mode_type rx_status;
      logic        word_valid;
      logic [3:0]  channel;
      logic        last;
   } rsp_load_type;

endpackage

@@ sv/crx_req_if.sv @@
`timescale 1ns / 1ps
interface crx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/crx_rsp_if.sv @@
`timescale 1ns / 1ps
interface crx_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  rx_status;
   logic        word_valid;
   logic [3:0]  channel;
   logic [31:0] payload_word;
   logic        last;

   modport source (output valid, output rx_status, output word_valid, output channel,
                   output payload_word, output last, input ready);
   modport sink   (input valid, input rx_status, input word_valid, input channel,
                   input payload_word, input last, output ready);
endinterface

@@ sv/checksummed_frame_receiver.sv @@
`timescale 1ns / 1ps
// channel  dir  transaction
// req_ch   in   one received byte (rx_byte)
// rsp_ch   out  rx_status, word_valid, channel, payload_word, last
//
// Each byte gives one transaction on rsp_ch, but a matching checksum
// byte starts a burst of ten words instead: each word is read from the
// registered payload RAM, then loaded; req_ch is held off during it.
// Synchronous reset returns to idle; no clearing pass is needed.
// A stalled rsp_ch stalls req_ch once the output register is full.
module checksummed_frame_receiver (
   input logic      clock,
   input logic      reset,
   crx_req_if.sink   req_ch,
   crx_rsp_if.source rsp_ch
);
   import crx_pkg::*;

   ram_cmd_type  ram_cmd;
   rsp_load_type rsp_load;
   logic [31:0]  rd_data;
   logic         out_free;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [1:0]   rx_status_ff;
   logic         word_valid_ff;
   logic [3:0]   channel_ff;
   logic [31:0]  payload_word_ff;
   logic         last_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   crx_frame_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rx_byte   (req_ch.rx_byte),
      .req_ready (req_ch.ready),
      .out_free  (out_free),
      .ram_cmd   (ram_cmd),
      .rsp_load  (rsp_load)
   );

   crx_payload_ram u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (rd_data)
   );

   always_comb begin
      if (rsp_load.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         rx_status_ff    <= rsp_load.rx_status;
         word_valid_ff   <= rsp_load.word_valid;
         channel_ff      <= rsp_load.channel;
         payload_word_ff <= rsp_load.word_valid ? rd_data : '0;
         last_ff         <= rsp_load.last;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.rx_status    = rx_status_ff;
   assign rsp_ch.word_valid   = word_valid_ff;
   assign rsp_ch.channel      = channel_ff;
   assign rsp_ch.payload_word = payload_word_ff;
   assign rsp_ch.last         = last_ff;

endmodule

@@ sv/crx_payload_ram.sv @@
`timescale 1ns / 1ps
module crx_payload_ram (
   input  logic                 clock,
   input  crx_pkg::ram_cmd_type cmd,
   output logic [31:0]          rd_data
);
   import crx_pkg::*;

   logic [3:0][7:0] mem [WORD_COUNT];
   logic [31:0]     rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr][cmd.wr_lane] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/crx_frame_ctrl.sv @@
`timescale 1ns / 1ps
module crx_frame_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [7:0]            rx_byte,
   output logic                  req_ready,
   input  logic                  out_free,
   output crx_pkg::ram_cmd_type  ram_cmd,
   output crx_pkg::rsp_load_type rsp_load
);
   import crx_pkg::*;
   `include "assert_macros.svh"

   fsm_state_type      state_ff, state_in;
   rx_mode_type        mode_ff, mode_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]         sum_ff, sum_in;
   logic [WADDR_W-1:0] idx_ff, idx_in;
   logic [7:0]         expect_sum;
   logic               accept;
   logic               match;
   logic               idx_last;

   assign accept     = req_valid && req_ready;
   assign expect_sum = sum_ff + START_BYTE;
   assign idx_last   = (idx_ff == WADDR_W'(WORD_COUNT - 1));

   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      match   = 1'b0;
      if (accept) begin
         unique case (mode_ff)
            MODE_COLLECT: begin
               cnt_in = cnt_ff + 1'b1;
               sum_in = sum_ff + rx_byte;
               if (cnt_in >= COUNT_W'(PAYLOAD_BYTES)) begin
                  mode_in = MODE_CHECK;
               end
            end
            MODE_CHECK: begin
               cnt_in = '0;
               sum_in = '0;
               if (expect_sum == rx_byte) begin
                  match   = 1'b1;
                  mode_in = MODE_DONE;
               end else begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDLE, MODE_DONE: begin
               if (rx_byte == START_BYTE) begin
                  mode_in = MODE_COLLECT;
                  cnt_in  = '0;
                  sum_in  = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_BYTE: begin
            if (accept && match) begin
               state_in = ST_READ;
               idx_in   = '0;
            end
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            if (out_free) begin
               if (idx_last) begin
                  state_in = ST_BYTE;
               end else begin
                  state_in = ST_READ;
                  idx_in   = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_BYTE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready        = (state_ff == ST_BYTE) && out_free;
      ram_cmd.wr_en    = accept && (mode_ff == MODE_COLLECT);
      ram_cmd.wr_addr  = WADDR_W'(cnt_ff >> 2);
      ram_cmd.wr_lane  = cnt_ff[1:0];
      ram_cmd.wr_data  = rx_byte;
      ram_cmd.rd_en    = (state_ff == ST_READ);
      ram_cmd.rd_addr  = idx_ff;
      if (state_ff == ST_LOAD) begin
         rsp_load.load       = out_free;
         rsp_load.rx_status  = MODE_DONE;
         rsp_load.word_valid = 1'b1;
         rsp_load.channel    = 4'(idx_ff);
         rsp_load.last       = idx_last;
      end else begin
         rsp_load.load       = accept && !match;
         rsp_load.rx_status  = mode_in;
         rsp_load.word_valid = 1'b0;
         rsp_load.channel    = '0;
         rsp_load.last       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BYTE;
         mode_ff  <= MODE_IDLE;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         idx_ff   <= idx_in;
      end
   end

   `ASSERT_ALWAYS(a_no_rw_overlap, !(ram_cmd.wr_en && ram_cmd.rd_en), "ram read and write overlap")
   `ASSERT_IMPLIES(a_burst_only_done, state_ff != ST_BYTE, mode_ff == MODE_DONE, "burst outside done")
   `ASSERT_IMPLIES(a_cnt_in_range, mode_ff == MODE_COLLECT, cnt_ff < COUNT_W'(PAYLOAD_BYTES), "byte count overrun")

endmodule

@@ tb/checksummed_frame_receiver_checker.sv @@
`timescale 1ns / 1ps
module checksummed_frame_receiver_checker (
   input  logic clock,
   input  logic reset,
   crx_req_if   req_ch,
   crx_rsp_if   rsp_ch,
   output int   pending,
   output int   error_count
);
   import crx_pkg::*;

   typedef struct packed {
      logic [1:0]  rx_status;
      logic        word_valid;
      logic [3:0]  channel;
      logic [31:0] payload_word;
      logic        last;
   } rx_beat_type;

   rx_mode_type mode;
   int          fill;
   logic [7:0]  sum;
   logic [7:0]  frame_bytes [PAYLOAD_BYTES];
   rx_beat_type beats_due [$];
   int          beats_seen;

   initial error_count = 0;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic receive_byte(input logic [7:0] b);
      rx_beat_type beat;
      logic [7:0]  want;
      int          k;
      case (mode)
         MODE_COLLECT: begin
            frame_bytes[fill] = b;
            fill++;
            sum = sum + b;
            if (fill == PAYLOAD_BYTES) mode = MODE_CHECK;
         end
         MODE_CHECK: begin
            want = sum + START_BYTE;
            sum  = '0;
            fill = 0;
            if (want == b) begin
               mode = MODE_DONE;
               for (k = 0; k < WORD_COUNT; k++) begin
                  beat.rx_status    = MODE_DONE;
                  beat.word_valid   = 1'b1;
                  beat.channel      = k[3:0];
                  beat.payload_word = {frame_bytes[4*k+3], frame_bytes[4*k+2],
                                       frame_bytes[4*k+1], frame_bytes[4*k]};
                  beat.last         = (k == WORD_COUNT - 1);
                  beats_due.push_back(beat);
               end
               return;
            end
            mode = MODE_IDLE;
         end
         default: begin
            if (b == START_BYTE) begin
               mode = MODE_COLLECT;
               fill = 0;
               sum  = '0;
            end
         end
      endcase
      beat = '{rx_status: mode, word_valid: 1'b0, channel: 4'd0, payload_word: 32'd0,
               last: 1'b1};
      beats_due.push_back(beat);
   endtask

   task automatic check_beat();
      rx_beat_type got, want;
      got = '{rsp_ch.rx_status, rsp_ch.word_valid, rsp_ch.channel, rsp_ch.payload_word,
              rsp_ch.last};
      beats_seen++;
      if (beats_due.size() == 0) begin
         report($sformatf("transaction %0d unexpected", beats_seen));
         return;
      end
      want = beats_due.pop_front();
      if (got !== want)
         report($sformatf({"transaction %0d: status %0d/%0d valid %b/%b ch %0d/%0d ",
                           "word %h/%h last %b/%b (got/want)"}, beats_seen,
                          got.rx_status, want.rx_status, got.word_valid, want.word_valid,
                          got.channel, want.channel, got.payload_word, want.payload_word,
                          got.last, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode       = MODE_IDLE;
         fill       = 0;
         sum        = '0;
         beats_seen = 0;
         beats_due.delete();
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_beat();
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) receive_byte(req_ch.rx_byte);
      end
      pending <= beats_due.size();
   end

endmodule

@@ tb/checksummed_frame_receiver_test.sv @@
`timescale 1ns / 1ps
module checksummed_frame_receiver_test;
   import crx_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 220;

   localparam int FILL_RANDOM = 0;
   localparam int FILL_ZEROS  = 1;
   localparam int FILL_ONES   = 2;
   localparam int FILL_START  = 3;

   logic clock;
   logic reset;
   int   pending;
   int   error_count;
   int   cycles = 0;
   int   sent = 0;
   bit   steady = 1'b0;

   crx_req_if req_ch ();
   crx_rsp_if rsp_ch ();

   checksummed_frame_receiver i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   checksummed_frame_receiver_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .pending     (pending),
      .error_count (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 8);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      sent++;
   endtask

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_frame(input bit good, input int fill_kind);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] chk;
      int         i;
      sum = '0;
      send_byte(START_BYTE);
      for (i = 0; i < PAYLOAD_BYTES; i++) begin
         case (fill_kind)
            FILL_ZEROS: b = 8'h00;
            FILL_ONES:  b = 8'hFF;
            FILL_START: b = START_BYTE;
            default:    b = 8'($urandom_range(0, 255));
         endcase
         sum = sum + b;
         send_byte(b);
      end
      chk = sum + START_BYTE;
      if (!good) chk = chk ^ 8'($urandom_range(1, 255));
      send_byte(chk);
   endtask

   // receiving side
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
      end
   end

   initial begin
      logic [7:0] idle_bytes [8];
      logic [7:0] b;
      int         pick;
      int         n;
      idle_bytes     = '{8'h00, 8'hFF, 8'h23, 8'h25, 8'h80, 8'h7F, 8'h01, 8'hFE};
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // non-start bytes while idle leave the receiver idle
      foreach (idle_bytes[i]) send_byte(idle_bytes[i]);
      send_frame(1'b1, FILL_ZEROS);
      // start bytes inside the payload, checksum wraps
      send_frame(1'b1, FILL_START);
      wait_drain();

      while (sent < RANDOM_ITEMS - 20) begin
         steady = ($urandom_range(0, 3) == 0);
         pick   = $urandom_range(0, 9);
         if (pick < 6) begin
            n = $urandom_range(0, 9);
            send_frame(1'b1, (n == 0) ? FILL_ONES : (n == 1) ? FILL_ZEROS :
                             (n == 2) ? FILL_START : FILL_RANDOM);
         end else if (pick < 8) begin
            send_frame(1'b0, FILL_RANDOM);
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               if (b == START_BYTE) b = b ^ 8'h01;
               send_byte(b);
            end
         end
      end

      wait_drain();
      repeat (30) @(posedge clock);
      if (error_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/crx_pkg.sv
sv/crx_req_if.sv
sv/crx_rsp_if.sv
sv/crx_payload_ram.sv
sv/crx_frame_ctrl.sv
sv/checksummed_frame_receiver.sv
tb/checksummed_frame_receiver_checker.sv
tb/checksummed_frame_receiver_test.sv
